>>> src/qef_pkg.sv
// ----------------------------------------------------------------------------
// qef_pkg
// Shared constants, types and register codes for the 3x3 quick edge filter.
// ----------------------------------------------------------------------------
package qef_pkg;

  // Geometry
  localparam int MAX_WIDTH  = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int DIM_W      = 11;
  localparam int PIX_W      = 8;
  localparam int KIND_W     = 1;
  localparam int LINE_W     = 2 * PIX_W;
  localparam int RES_AW     = COL_W + 1;
  localparam int RES_DEPTH  = 2 ** RES_AW;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  // Width and height limits as used by the datapath
  localparam logic [DIM_W-1:0] WIDTH_CAP =
    DIM_W'((MAX_WIDTH < 2 ** DIM_W) ? MAX_WIDTH : 2 ** DIM_W - 1);
  localparam logic [DIM_W-1:0] DIM_MIN  = DIM_W'(3);
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_WIDTH - 1);

  // Register reset values
  localparam logic [DIM_W-1:0] RST_FRAME_WIDTH  = DIM_W'(640);
  localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = DIM_W'(480);
  localparam logic             RST_FOUR_BIT     = 1'b0;
  localparam logic             RST_TH_EN        = 1'b1;
  localparam logic [PIX_W-1:0] RST_TH_HIGH      = PIX_W'(90);

  // Clamp limits and threshold markers
  localparam logic [PIX_W-1:0] LIMIT_8   = PIX_W'(255);
  localparam logic [PIX_W-1:0] LIMIT_4   = PIX_W'(16);
  localparam logic [PIX_W-1:0] MARK_HI_8 = PIX_W'(250);
  localparam logic [PIX_W-1:0] MARK_LO_8 = PIX_W'(16);
  localparam logic [PIX_W-1:0] MARK_HI_4 = PIX_W'(10);
  localparam logic [PIX_W-1:0] MARK_LO_4 = PIX_W'(3);

  // Input word kinds
  localparam logic [KIND_W-1:0] KIND_DRAIN = 1'b1;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_FOUR_BIT     = 3'd2,
    REG_TH_EN        = 3'd3,
    REG_TH_HIGH      = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [DIM_W-1:0] frame_width;
    logic [DIM_W-1:0] frame_height;
    logic             four_bit;
    logic             th_en;
    logic [PIX_W-1:0] th_high;
  } cfg_t;

  // One word as decoded by the front stage
  typedef struct packed {
    logic              pix_op;   // pixel word: shifts window, writes line store
    logic              emit;     // produces one output word
    logic              do_sum;   // writes one result into the result store
    logic [COL_W-1:0]  col;      // line store column
    logic [RES_AW-1:0] waddr;    // result store write entry {bank, col}
    logic [RES_AW-1:0] raddr;    // result store read entry {bank, col}
    logic              last;     // final output position of the frame
    logic [PIX_W-1:0]  pix;
  } item_t;

endpackage

>>> src/qef_in_if.sv
// ----------------------------------------------------------------------------
// qef_in_if
// Input word channel: valid/ready handshake with word kind and pixel.
// ----------------------------------------------------------------------------
interface qef_in_if;
  import qef_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [PIX_W-1:0]  pixel_in;

  modport source (output valid, output kind, output pixel_in, input ready);
  modport sink   (input valid, input kind, input pixel_in, output ready);

endinterface

>>> src/qef_out_if.sv
// ----------------------------------------------------------------------------
// qef_out_if
// Result word channel: valid/ready handshake with pixel and end-of-frame flag.
// ----------------------------------------------------------------------------
interface qef_out_if;
  import qef_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             last_of_frame;

  modport source (output valid, output pixel_out, output last_of_frame, input ready);
  modport sink   (input valid, input pixel_out, input last_of_frame, output ready);

endinterface

>>> src/qef_ram.sv
// ----------------------------------------------------------------------------
// qef_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module qef_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents on a same-entry write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/qef_seq.sv
// ----------------------------------------------------------------------------
// qef_seq
// Front stage: input and output position counters, word decode and store
// address generation.
// ----------------------------------------------------------------------------
module qef_seq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  qef_pkg::cfg_t                cfg,
  input  logic                         accept,
  input  logic [qef_pkg::KIND_W-1:0]   kind,
  input  logic [qef_pkg::PIX_W-1:0]    pixel_in,
  output qef_pkg::item_t               item
);
  import qef_pkg::*;

  logic [DIM_W-1:0] in_row_r, in_col_r, out_row_r, out_col_r;
  logic [DIM_W-1:0] in_row_nxt, in_col_nxt, out_row_nxt, out_col_nxt;
  logic [DIM_W-1:0] w_eff, h_eff, w_m1, w_m2, h_m1, h_m2;
  logic [DIM_W-1:0] orow, ocol, crow, ccol;
  logic [DIM_W:0]   in_col_inc, in_row_inc, out_col_inc, out_row_inc;
  logic             is_drain, at_start, col_ge2, emit_pix, emit;
  logic [COL_W-1:0] col;

  // Effective frame size
  always_comb begin
    w_eff = cfg.frame_width;
    if (cfg.frame_width < DIM_MIN) begin
      w_eff = DIM_MIN;
    end else if (cfg.frame_width > WIDTH_CAP) begin
      w_eff = WIDTH_CAP;
    end
    h_eff = (cfg.frame_height < DIM_MIN) ? DIM_MIN : cfg.frame_height;
    w_m1  = w_eff - DIM_W'(1);
    w_m2  = w_eff - DIM_W'(2);
    h_m1  = h_eff - DIM_W'(1);
    h_m2  = h_eff - DIM_W'(2);
  end

  // Decode the word at the current positions
  always_comb begin
    is_drain = (kind == KIND_DRAIN);
    at_start = (in_row_r == '0) && (in_col_r == '0);
    col      = (in_col_r >= WIDTH_CAP) ? COL_LAST : COL_W'(in_col_r);
    col_ge2  = (col >= COL_W'(2));
    emit_pix = (in_row_r > DIM_W'(2)) || ((in_row_r == DIM_W'(2)) && col_ge2);
    emit     = is_drain ? (at_start && ((out_row_r != '0) || (out_col_r != '0)))
                        : emit_pix;

    // a pixel at frame start drops whatever output is still pending
    orow = (!is_drain && at_start) ? '0 : out_row_r;
    ocol = (!is_drain && at_start) ? '0 : out_col_r;

    // border positions read the nearest interior result
    crow = orow;
    if (orow < DIM_W'(1)) begin
      crow = DIM_W'(1);
    end else if (orow > h_m2) begin
      crow = h_m2;
    end
    ccol = ocol;
    if (ocol < DIM_W'(1)) begin
      ccol = DIM_W'(1);
    end else if (ocol > w_m2) begin
      ccol = w_m2;
    end

    item.pix_op = !is_drain;
    item.emit   = emit;
    item.do_sum = !is_drain && (in_row_r >= DIM_W'(2)) && col_ge2;
    item.col    = col;
    item.waddr  = {~in_row_r[0], col - COL_W'(1)};
    item.raddr  = {crow[0], COL_W'(ccol)};
    item.last   = (orow == h_m1) && (ocol == w_m1);
    item.pix    = pixel_in;
  end

  // Counter advance
  always_comb begin
    in_col_inc  = (DIM_W+1)'(in_col_r) + (DIM_W+1)'(1);
    in_row_inc  = (DIM_W+1)'(in_row_r) + (DIM_W+1)'(1);
    out_col_inc = (DIM_W+1)'(ocol) + (DIM_W+1)'(1);
    out_row_inc = (DIM_W+1)'(orow) + (DIM_W+1)'(1);

    in_row_nxt = in_row_r;
    in_col_nxt = in_col_r;
    if (!is_drain) begin
      if (in_col_inc >= (DIM_W+1)'(w_eff)) begin
        in_col_nxt = '0;
        in_row_nxt = (in_row_inc >= (DIM_W+1)'(h_eff)) ? '0 : in_row_inc[DIM_W-1:0];
      end else begin
        in_col_nxt = in_col_inc[DIM_W-1:0];
      end
    end

    out_row_nxt = orow;
    out_col_nxt = ocol;
    if (emit) begin
      if (out_col_inc >= (DIM_W+1)'(w_eff)) begin
        out_col_nxt = '0;
        out_row_nxt = (out_row_inc >= (DIM_W+1)'(h_eff)) ? '0 : out_row_inc[DIM_W-1:0];
      end else begin
        out_col_nxt = out_col_inc[DIM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_row_r  <= '0;
      in_col_r  <= '0;
      out_row_r <= '0;
      out_col_r <= '0;
    end else if (accept) begin
      in_row_r  <= in_row_nxt;
      in_col_r  <= in_col_nxt;
      out_row_r <= out_row_nxt;
      out_col_r <= out_col_nxt;
    end
  end

endmodule

>>> src/qef_kernel.sv
// ----------------------------------------------------------------------------
// qef_kernel
// 3x3 window taps, corner/center mask sum, clamp and threshold.
// ----------------------------------------------------------------------------
module qef_kernel (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      shift,
  input  logic [qef_pkg::PIX_W-1:0] top,
  input  logic [qef_pkg::PIX_W-1:0] mid,
  input  logic [qef_pkg::PIX_W-1:0] pix,
  input  qef_pkg::cfg_t             cfg,
  output logic [qef_pkg::PIX_W-1:0] fin
);
  import qef_pkg::*;

  // Window taps that reach the mask: two columns of the top and bottom rows,
  // the middle column of the middle row. Edge weights are zero.
  logic [PIX_W-1:0] top1_r, top2_r, mid2_r, bot1_r, bot2_r;
  logic [11:0]      pos, neg;
  logic signed [11:0] diff;
  logic [PIX_W-1:0] limit, cl, mark_hi, mark_lo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top1_r <= '0;
      top2_r <= '0;
      mid2_r <= '0;
      bot1_r <= '0;
      bot2_r <= '0;
    end else if (shift) begin
      top1_r <= top2_r;
      top2_r <= top;
      mid2_r <= mid;
      bot1_r <= bot2_r;
      bot2_r <= pix;
    end
  end

  // Mask over the shifted window: 4*center minus the four corners
  always_comb begin
    pos  = {2'b00, mid2_r, 2'b00};
    neg  = 12'(top1_r) + 12'(top) + 12'(bot1_r) + 12'(pix);
    diff = $signed(pos) - $signed(neg);

    limit   = cfg.four_bit ? LIMIT_4 : LIMIT_8;
    mark_hi = cfg.four_bit ? MARK_HI_4 : MARK_HI_8;
    mark_lo = cfg.four_bit ? MARK_LO_4 : MARK_LO_8;

    if (diff[11]) begin
      cl = '0;
    end else if (diff[10:0] > 11'(limit)) begin
      cl = limit;
    end else begin
      cl = diff[PIX_W-1:0];
    end

    if (cfg.th_en) begin
      fin = (cl > cfg.th_high) ? mark_hi : mark_lo;
    end else begin
      fin = cl;
    end
  end

endmodule

>>> src/quick_edge_filter_3x3_unit.sv
// ----------------------------------------------------------------------------
// quick_edge_filter_3x3_unit
// Streaming 3x3 quick edge filter with two line stores and a two-bank result
// row store, both in synchronous RAM.
// Timing: an output word passes stage registers B, C and D, then the output
//   register or skid slot; outputs trail inputs by 2*W+2 words per frame.
// Throughput: one word per cycle; the line RAM and the result RAM are each read
//   once and written once per word on separate ports. A stalled output stops
//   input only once the skid slot behind the output register fills.
// Reset: counters, window taps, pipeline valids, output buffer and config
//   registers clear at once; the RAMs are not cleared and need no pass.
// ----------------------------------------------------------------------------
module quick_edge_filter_3x3_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  qef_in_if.sink                         in_chan,
  qef_out_if.source                      out_chan,
  input  logic                           cfg_we,
  input  logic [qef_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [qef_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import qef_pkg::*;

  cfg_t              cfg_r;
  logic              adv, accept;
  item_t             item_a, b_item_r;
  logic              b_pix_r, b_emit_r;
  logic [LINE_W-1:0] line_q;
  logic [PIX_W-1:0]  line_top, line_mid, fin;
  logic              c_wr_r, c_emit_r, c_last_r;
  logic [RES_AW-1:0] c_waddr_r, c_raddr_r;
  logic [PIX_W-1:0]  c_fin_r;
  logic [PIX_W-1:0]  res_q, d_val;
  logic              d_emit_r, d_fwd_r, d_last_r;
  logic [PIX_W-1:0]  d_fin_r;
  logic              out_vld_r, skid_vld_r, push, pop;
  logic [PIX_W-1:0]  out_pix_r, skid_pix_r;
  logic              out_last_r, skid_last_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width  <= RST_FRAME_WIDTH;
      cfg_r.frame_height <= RST_FRAME_HEIGHT;
      cfg_r.four_bit     <= RST_FOUR_BIT;
      cfg_r.th_en        <= RST_TH_EN;
      cfg_r.th_high      <= RST_TH_HIGH;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_FRAME_WIDTH:  cfg_r.frame_width  <= cfg_wdata;
        REG_FRAME_HEIGHT: cfg_r.frame_height <= cfg_wdata;
        REG_FOUR_BIT:     cfg_r.four_bit     <= cfg_wdata[0];
        REG_TH_EN:        cfg_r.th_en        <= cfg_wdata[0];
        REG_TH_HIGH:      cfg_r.th_high      <= cfg_wdata[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline advances while the skid slot is free
  assign adv            = !skid_vld_r;
  assign in_chan.ready  = adv;
  assign accept         = in_chan.valid && adv;

  // Stage A: decode and counters, line RAM read
  qef_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .accept   (accept),
    .kind     (in_chan.kind),
    .pixel_in (in_chan.pixel_in),
    .item     (item_a)
  );

  // Line RAM entry: {upper row, middle row} per column
  qef_ram #(.WIDTH(LINE_W), .DEPTH(MAX_WIDTH)) u_line_ram (
    .clk   (clk),
    .we    (adv && b_pix_r),
    .waddr (b_item_r.col),
    .wdata ({line_mid, b_item_r.pix}),
    .re    (accept),
    .raddr (item_a.col),
    .rdata (line_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_pix_r  <= 1'b0;
      b_emit_r <= 1'b0;
    end else if (adv) begin
      b_pix_r  <= accept && item_a.pix_op;
      b_emit_r <= accept && item_a.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_item_r <= item_a;
    end
  end

  // Stage B: line data back, window shift, mask and finish
  assign line_top = line_q[LINE_W-1:PIX_W];
  assign line_mid = line_q[PIX_W-1:0];

  qef_kernel u_kernel (
    .clk   (clk),
    .rst_n (rst_n),
    .shift (adv && b_pix_r),
    .top   (line_top),
    .mid   (line_mid),
    .pix   (b_item_r.pix),
    .cfg   (cfg_r),
    .fin   (fin)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_wr_r   <= 1'b0;
      c_emit_r <= 1'b0;
    end else if (adv) begin
      c_wr_r   <= b_pix_r && b_item_r.do_sum;
      c_emit_r <= b_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_waddr_r <= b_item_r.waddr;
      c_raddr_r <= b_item_r.raddr;
      c_last_r  <= b_item_r.last;
      c_fin_r   <= fin;
    end
  end

  // Stage C: result RAM write and read; same entry is forwarded
  qef_ram #(.WIDTH(PIX_W), .DEPTH(RES_DEPTH)) u_res_ram (
    .clk   (clk),
    .we    (adv && c_wr_r),
    .waddr (c_waddr_r),
    .wdata (c_fin_r),
    .re    (adv && c_emit_r),
    .raddr (c_raddr_r),
    .rdata (res_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_emit_r <= 1'b0;
    end else if (adv) begin
      d_emit_r <= c_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_fwd_r  <= c_wr_r && (c_waddr_r == c_raddr_r);
      d_fin_r  <= c_fin_r;
      d_last_r <= c_last_r;
    end
  end

  // Stage D: pick forwarded or stored result
  assign d_val = d_fwd_r ? d_fin_r : res_q;
  assign push  = adv && d_emit_r;
  assign pop   = out_vld_r && out_chan.ready;

  // Output register with one skid slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (pop) begin
        skid_vld_r <= 1'b0;
      end
    end else if (push) begin
      if (out_vld_r && !out_chan.ready) begin
        skid_vld_r <= 1'b1;
      end else begin
        out_vld_r <= 1'b1;
      end
    end else if (pop) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (pop) begin
        out_pix_r  <= skid_pix_r;
        out_last_r <= skid_last_r;
      end
    end else if (push) begin
      if (out_vld_r && !out_chan.ready) begin
        skid_pix_r  <= d_val;
        skid_last_r <= d_last_r;
      end else begin
        out_pix_r  <= d_val;
        out_last_r <= d_last_r;
      end
    end
  end

  assign out_chan.valid         = out_vld_r;
  assign out_chan.pixel_out     = out_pix_r;
  assign out_chan.last_of_frame = out_last_r;

  // Line RAM read and the write one stage ahead never share a column
  a_line_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && item_a.pix_op && b_pix_r) |-> (item_a.col != b_item_r.col))
    else $error("line RAM read/write overlap on one column");

  // Skid slot only holds a word behind a waiting output word
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid slot full with output register empty");

  // Skid slot fills only when a push meets a stalled output
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_vld_r) |-> $past(push && out_vld_r && !out_chan.ready))
    else $error("skid slot filled without a stalled output");

endmodule

>>> dv/quick_edge_filter_3x3_unit_tb.sv
// ----------------------------------------------------------------------------
// quick_edge_filter_3x3_unit_tb
// Self-checking bench for the 3x3 quick edge filter. A driver sends pixel and
// drain words from a queue. A behavioral predictor follows every accepted
// input word and keeps its own line stores, window and result rows. A monitor
// checks each output word against the oldest predicted one. The run covers
// directed frames, a wide frame, a tall narrow frame, and many small random
// frames. The random frames include undrained frames, threshold changes
// inside a frame, and random stalls on both channels.
// ----------------------------------------------------------------------------
module quick_edge_filter_3x3_unit_tb;
  import qef_pkg::*;

  localparam logic [KIND_W-1:0] KIND_PIXEL = ~KIND_DRAIN;
  localparam int SETTLE_CYCLES = 8;     // pipeline is 4 deep
  localparam int STALL_LIMIT   = 2000;  // cycles with no word moving
  localparam int RANDOM_WORDS  = 1100;
  localparam int WIDE_W        = 100;
  localparam int TALL_H        = 100;

  typedef enum int {TEX_UNIFORM, TEX_BINARY, TEX_DIM, TEX_FLAT} texture_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [PIX_W-1:0]  pix;
  } in_word_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             last;
  } edge_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  qef_in_if  in_if ();
  qef_out_if out_if ();

  quick_edge_filter_3x3_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Word queues and run statistics
  in_word_t     words_to_send [$];
  edge_result_t results_due [$];
  bit           idle_on = 1'b1;
  int           errors = 0;
  int           results_checked = 0;
  int           pixels_seen = 0;
  int           drains_seen = 0;
  int           frames_sent = 0;

  // Predictor: register copy, stores, window taps and position counters
  logic [DIM_W-1:0] reg_width    = RST_FRAME_WIDTH;
  logic [DIM_W-1:0] reg_height   = RST_FRAME_HEIGHT;
  logic             reg_four_bit = RST_FOUR_BIT;
  logic             reg_th_en    = RST_TH_EN;
  logic [PIX_W-1:0] reg_th_high  = RST_TH_HIGH;

  logic [PIX_W-1:0] line_upper  [MAX_WIDTH];
  logic [PIX_W-1:0] line_middle [MAX_WIDTH];
  logic [PIX_W-1:0] result_rows [2][MAX_WIDTH];
  logic [PIX_W-1:0] taps [9] = '{default: '0};
  int in_row = 0, in_col = 0, out_row = 0, out_col = 0;

  function automatic int eff_width(logic [DIM_W-1:0] v);
    if (v < 3) return 3;
    if (v > MAX_WIDTH) return MAX_WIDTH;
    return int'(v);
  endfunction

  function automatic int eff_height(logic [DIM_W-1:0] v);
    return (v < 3) ? 3 : int'(v);
  endfunction

  // Clamp, then optional threshold to marker values
  function automatic logic [PIX_W-1:0] grade_sum(int sum);
    int limit;
    limit = reg_four_bit ? int'(LIMIT_4) : int'(LIMIT_8);
    if (sum < 0) sum = 0;
    if (sum > limit) sum = limit;
    if (reg_th_en) begin
      if (sum > int'(reg_th_high)) return reg_four_bit ? MARK_HI_4 : MARK_HI_8;
      return reg_four_bit ? MARK_LO_4 : MARK_LO_8;
    end
    return PIX_W'(sum);
  endfunction

  // Output position takes the nearest interior result, then advances
  function automatic void emit_position();
    int w, h, cr, cc;
    edge_result_t res;
    w = eff_width(reg_width);
    h = eff_height(reg_height);
    cr = (out_row < 1) ? 1 : (out_row > h - 2) ? h - 2 : out_row;
    cc = (out_col < 1) ? 1 : (out_col > w - 2) ? w - 2 : out_col;
    res.pix  = result_rows[cr % 2][cc];
    res.last = (out_row == h - 1) && (out_col == w - 1);
    results_due.push_back(res);
    if (out_col + 1 >= w) begin
      out_col = 0;
      out_row = (out_row + 1 >= h) ? 0 : out_row + 1;
    end else begin
      out_col++;
    end
  endfunction

  // One accepted input word through the filter
  function automatic void filter_word(logic [KIND_W-1:0] kind, logic [PIX_W-1:0] pix);
    int   w, h, c, sum;
    logic at_start, emit;
    w = eff_width(reg_width);
    h = eff_height(reg_height);
    at_start = (in_row == 0) && (in_col == 0);
    if (kind == KIND_DRAIN) begin
      drains_seen++;
      // flushes only between frames with outputs still pending
      if (at_start && (out_row != 0 || out_col != 0)) emit_position();
      return;
    end
    pixels_seen++;
    // a new frame drops whatever the last one left pending
    if (at_start) begin
      out_row = 0;
      out_col = 0;
    end
    c = (in_col < MAX_WIDTH) ? in_col : MAX_WIDTH - 1;
    for (int i = 0; i < 3; i++) begin
      taps[i*3]   = taps[i*3 + 1];
      taps[i*3+1] = taps[i*3 + 2];
    end
    taps[2] = line_upper[c];
    taps[5] = line_middle[c];
    taps[8] = pix;
    line_upper[c]  = line_middle[c];
    line_middle[c] = pix;
    if (in_row >= 2 && c >= 2) begin
      sum = 4 * int'(taps[4]) - int'(taps[0]) - int'(taps[2])
            - int'(taps[6]) - int'(taps[8]);
      result_rows[(in_row - 1) % 2][c - 1] = grade_sum(sum);
    end
    emit = (in_row > 2) || (in_row == 2 && c >= 2);
    if (in_col + 1 >= w) begin
      in_col = 0;
      in_row = (in_row + 1 >= h) ? 0 : in_row + 1;
    end else begin
      in_col++;
    end
    if (emit) emit_position();
  endfunction

  // Input driver: bursts of idle, otherwise next queued word
  int send_gap = 0;
  always @(posedge clk) begin
    in_word_t nxt;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      if (send_gap > 0) begin
        send_gap--;
        in_if.valid <= 1'b0;
      end else if (words_to_send.size() == 0) begin
        in_if.valid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        send_gap = $urandom_range(0, 18);
        in_if.valid <= 1'b0;
      end else begin
        nxt = words_to_send.pop_front();
        in_if.valid    <= 1'b1;
        in_if.kind     <= nxt.kind;
        in_if.pixel_in <= nxt.pix;
      end
    end
  end

  // Output sink: random stall bursts
  int sink_gap = 0;
  always @(posedge clk) begin
    if (sink_gap > 0) begin
      sink_gap--;
      out_if.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      sink_gap = $urandom_range(0, 18);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Predict on every accepted input word
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) filter_word(in_if.kind, in_if.pixel_in);
  end

  // Check every accepted output word
  always @(posedge clk) begin
    edge_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      results_checked++;
      if (results_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected word: expected none, actual pixel_out=%0d last=%0b",
                 $time, out_if.pixel_out, out_if.last_of_frame);
      end else begin
        want = results_due.pop_front();
        if (out_if.pixel_out !== want.pix) begin
          errors++;
          $display("%0t: pixel_out expected %0d, actual %0d",
                   $time, want.pix, out_if.pixel_out);
        end
        if (out_if.last_of_frame !== want.last) begin
          errors++;
          $display("%0t: last_of_frame expected %0b, actual %0b",
                   $time, want.last, out_if.last_of_frame);
        end
      end
    end
  end

  // Watchdog on words moving
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("quick_edge_filter_3x3_unit: mismatch");
        $finish;
      end
    end
  end

  function automatic void push_word(logic [KIND_W-1:0] k, logic [PIX_W-1:0] p);
    in_word_t nw;
    nw.kind = k;
    nw.pix  = p;
    words_to_send.push_back(nw);
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel(texture_t tex);
    case (tex)
      TEX_BINARY: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      TEX_DIM:    return PIX_W'($urandom_range(0, 15));
      TEX_FLAT:   return ($urandom_range(0, 3) == 0) ? PIX_W'($urandom) : 8'd128;
      default:    return PIX_W'($urandom);
    endcase
  endfunction

  // Nothing queued, nothing in flight, nothing owed; then let the pipe settle
  task automatic wait_idle();
    do @(negedge clk);
    while (words_to_send.size() != 0 || in_if.valid || results_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= r;
    cfg_wdata <= v;
    case (r)
      REG_FRAME_WIDTH:  reg_width    = v;
      REG_FRAME_HEIGHT: reg_height   = v;
      REG_FOUR_BIT:     reg_four_bit = v[0];
      REG_TH_EN:        reg_th_en    = v[0];
      REG_TH_HIGH:      reg_th_high  = v[PIX_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mode, enable and level; unused upper data bits carry junk
  task automatic retune_thresholds();
    logic [CFG_DATA_W-1:0] junk;
    logic [PIX_W-1:0]      th;
    junk = CFG_DATA_W'($urandom);
    case ($urandom_range(0, 3))
      0:       th = 8'd0;
      1:       th = 8'd255;
      2:       th = PIX_W'($urandom_range(0, 20));
      default: th = PIX_W'($urandom);
    endcase
    write_reg(REG_FOUR_BIT, {junk[CFG_DATA_W-1:1], 1'($urandom_range(0, 1))});
    write_reg(REG_TH_EN,    {junk[CFG_DATA_W-1:1], 1'($urandom_range(0, 1))});
    write_reg(REG_TH_HIGH,  {junk[CFG_DATA_W-1:PIX_W], th});
  endtask

  // One frame at the current size, optional retune at pixel 'split'
  task automatic run_frame(texture_t tex, int split, int drains, bit noisy);
    int w, h;
    w = eff_width(reg_width);
    h = eff_height(reg_height);
    frames_sent++;
    for (int n = 0; n < w * h; n++) begin
      if (n == split) begin
        wait_idle();
        retune_thresholds();
      end
      // drain inside a frame does nothing
      if (noisy && n > 0 && $urandom_range(0, 15) == 0) push_word(KIND_DRAIN, PIX_W'($urandom));
      push_word(KIND_PIXEL, pick_pixel(tex));
    end
    for (int n = 0; n < drains; n++) push_word(KIND_DRAIN, PIX_W'($urandom));
  endtask

  // Stimulus
  initial begin
    int counted, w, h, split, drains;
    counted = 0;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = REG_FRAME_WIDTH;
    cfg_wdata      = '0;
    in_if.valid    = 1'b0;
    in_if.kind     = KIND_PIXEL;
    in_if.pixel_in = '0;
    out_if.ready   = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // 3x3 frame, reset thresholds: bright center on black saturates high
    write_reg(REG_FRAME_WIDTH, 11'd3);
    write_reg(REG_FRAME_HEIGHT, 11'd3);
    frames_sent++;
    for (int n = 0; n < 9; n++) begin
      if (n == 5) push_word(KIND_DRAIN, 8'hFF);
      push_word(KIND_PIXEL, (n == 4) ? 8'hFF : 8'h00);
    end
    repeat (8) push_word(KIND_DRAIN, 8'h00);
    wait_idle();

    // raw 4-bit output, bright corners go below zero; frame left undrained
    write_reg(REG_FOUR_BIT, 11'd1);
    write_reg(REG_TH_EN, 11'd0);
    write_reg(REG_TH_HIGH, 11'd0);
    frames_sent++;
    for (int n = 0; n < 9; n++)
      push_word(KIND_PIXEL, (n == 0 || n == 2 || n == 6 || n == 8) ? 8'hFF : 8'h00);
    wait_idle();

    // wide frame, height register below 3; one spare drain at the end
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(WIDE_W));
    write_reg(REG_FRAME_HEIGHT, 11'd2);
    write_reg(REG_FOUR_BIT, 11'd0);
    run_frame(TEX_UNIFORM, -1, 2 * WIDE_W + 3, 1'b0);
    wait_idle();

    // tall frame at the narrowest width, level at its top
    write_reg(REG_FRAME_WIDTH, 11'd0);
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(TALL_H));
    write_reg(REG_TH_EN, 11'd1);
    write_reg(REG_TH_HIGH, 11'd255);
    run_frame(TEX_BINARY, -1, 8, 1'b0);

    // small random frames; the last tenth runs with no stalls
    while (counted < RANDOM_WORDS) begin
      wait_idle();
      idle_on = (counted > RANDOM_WORDS * 9 / 10) ? 1'b0 : ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 6))
        0:       write_reg(REG_FRAME_WIDTH, CFG_DATA_W'($urandom_range(0, 2)));
        1:       write_reg(REG_FRAME_WIDTH, CFG_DATA_W'($urandom_range(13, 40)));
        default: write_reg(REG_FRAME_WIDTH, CFG_DATA_W'($urandom_range(3, 12)));
      endcase
      case ($urandom_range(0, 9))
        0, 1:    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'($urandom_range(0, 2)));
        2:       write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'($urandom_range(8, 16)));
        default: write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'($urandom_range(3, 7)));
      endcase
      if ($urandom_range(0, 1) != 0) retune_thresholds();
      w = eff_width(reg_width);
      h = eff_height(reg_height);
      split  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, w * h - 1) : -1;
      drains = ($urandom_range(0, 9) < 7) ? 2 * w + 2 + $urandom_range(0, 2)
                                          : $urandom_range(0, 2 * w + 1);
      run_frame(texture_t'($urandom_range(0, 3)), split, drains, $urandom_range(0, 1) != 0);
      counted += w * h + ((drains < 2 * w + 2) ? drains : 2 * w + 2);
    end
    wait_idle();

    $display("covered %0d frames: %0d pixel words, %0d drain words, %0d results checked",
             frames_sent, pixels_seen, drains_seen, results_checked);
    $display("sizes from 3x3 up to %0d wide and %0d tall, 8/4-bit, threshold on/off",
             WIDE_W, TALL_H);
    if (errors == 0) begin
      $display("quick_edge_filter_3x3_unit: match");
    end else begin
      $display("quick_edge_filter_3x3_unit: mismatch");
    end
    $finish;
  end

endmodule
